@@ hw/rtl/dios_pkg.sv @@
// dios_pkg: shared types, codes and defaults for the deadline i/o scheduler
// used by dios_cell, dios_sort_table and deadline_io_scheduler
package dios_pkg;

    localparam int MAX_REQUESTS_DEF = 64;
    localparam int MAX_BATCH_DEF    = 8;

    localparam int SECTOR_W = 16;
    localparam int ID_W     = 16;
    localparam int TIME_W   = 32;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    localparam logic [1:0] KIND_ACCEPT   = 2'd0;
    localparam logic [1:0] KIND_DROP     = 2'd1;
    localparam logic [1:0] KIND_DISPATCH = 2'd2;

    localparam logic [1:0] REG_READ_DL  = 2'd0;
    localparam logic [1:0] REG_WRITE_DL = 2'd1;
    localparam logic [1:0] REG_STARVED  = 2'd2;
    localparam logic [1:0] REG_BATCH    = 2'd3;

    localparam logic [15:0] READ_DL_RST  = 16'd500;
    localparam logic [15:0] WRITE_DL_RST = 16'd5000;
    localparam logic [7:0]  STARVED_RST  = 8'd2;
    localparam logic [3:0]  BATCH_RST    = 4'd5;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [TIME_W-1:0]   expiry;
        logic [ID_W-1:0]     id;
        logic                is_write;
    } store_t;

    typedef struct packed {
        logic                ins;
        logic                pop;
        logic [SECTOR_W-1:0] sector;
    } tbl_ctrl_t;

endpackage

@@ hw/rtl/dios_fifo.sv @@
// dios_fifo: slot index queue held in a memory, registered head read
// depends on nothing
module dios_fifo #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             empty
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    head_reg, tail_reg;
    logic [CW-1:0]    count_reg;
    logic [WIDTH-1:0] rd_reg;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
        if (idx == AW'(DEPTH - 1))
            return '0;
        else
            return idx + AW'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail_reg] <= push_data;
        end
        rd_reg <= mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                tail_reg <= wrap_inc(tail_reg);
            end
            if (pop)
            begin
                head_reg <= wrap_inc(head_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    assign head_data = rd_reg;
    assign empty     = (count_reg == '0);
endmodule

@@ hw/rtl/dios_cell.sv @@
// dios_cell: one place of the sector ordered table
// depends on dios_pkg
module dios_cell #(
    parameter int SLOT_W = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dios_pkg::tbl_ctrl_t           ctrl,
    input  logic [SLOT_W-1:0]             new_slot,
    input  logic                          left_valid,
    input  logic                          left_gt,
    input  logic [dios_pkg::SECTOR_W-1:0] left_sector,
    input  logic [SLOT_W-1:0]             left_slot,
    input  logic                          right_valid,
    input  logic [dios_pkg::SECTOR_W-1:0] right_sector,
    input  logic [SLOT_W-1:0]             right_slot,
    output logic                          valid,
    output logic [dios_pkg::SECTOR_W-1:0] sector,
    output logic [SLOT_W-1:0]             slot,
    output logic                          gt
);
    import dios_pkg::*;

    logic                valid_reg;
    logic [SECTOR_W-1:0] sector_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic                ins_here;

    assign gt       = valid_reg && (sector_reg > ctrl.sector);
    assign ins_here = ctrl.ins && (gt || (!valid_reg && left_valid));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ins_here)
        begin
            valid_reg <= 1'b1;
        end
        else if (ctrl.pop)
        begin
            valid_reg <= right_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ins_here)
        begin
            sector_reg <= left_gt ? left_sector : ctrl.sector;
            slot_reg   <= left_gt ? left_slot : new_slot;
        end
        else if (ctrl.pop)
        begin
            sector_reg <= right_sector;
            slot_reg   <= right_slot;
        end
    end

    assign valid  = valid_reg;
    assign sector = sector_reg;
    assign slot   = slot_reg;
endmodule

@@ hw/rtl/dios_sort_table.sv @@
// dios_sort_table: chain of dios_cell places kept in sector order
// depends on dios_pkg and dios_cell
module dios_sort_table #(
    parameter int DEPTH  = 64,
    parameter int SLOT_W = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dios_pkg::tbl_ctrl_t ctrl,
    input  logic [SLOT_W-1:0]   new_slot,
    output logic                head_valid,
    output logic [SLOT_W-1:0]   head_slot
);
    import dios_pkg::*;

    logic                v   [DEPTH];
    logic                g   [DEPTH];
    logic [SECTOR_W-1:0] sec [DEPTH];
    logic [SLOT_W-1:0]   sl  [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                lv, lg, rv;
        logic [SECTOR_W-1:0] ls, rs;
        logic [SLOT_W-1:0]   lsl, rsl;

        if (i == 0)
        begin : g_first
            assign lv  = 1'b1;
            assign lg  = 1'b0;
            assign ls  = '0;
            assign lsl = '0;
        end
        else
        begin : g_mid
            assign lv  = v[i-1];
            assign lg  = g[i-1];
            assign ls  = sec[i-1];
            assign lsl = sl[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign rv  = 1'b0;
            assign rs  = '0;
            assign rsl = '0;
        end
        else
        begin : g_inner
            assign rv  = v[i+1];
            assign rs  = sec[i+1];
            assign rsl = sl[i+1];
        end

        dios_cell #(.SLOT_W(SLOT_W)) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .new_slot     (new_slot),
            .left_valid   (lv),
            .left_gt      (lg),
            .left_sector  (ls),
            .left_slot    (lsl),
            .right_valid  (rv),
            .right_sector (rs),
            .right_slot   (rsl),
            .valid        (v[i]),
            .sector       (sec[i]),
            .slot         (sl[i]),
            .gt           (g[i])
        );
    end

    assign head_valid = v[0];
    assign head_slot  = sl[0];
endmodule

@@ hw/rtl/deadline_io_scheduler.sv @@
// deadline_io_scheduler: arrival, ordering and batch dispatch of disk requests
// arrival: free slot scan, one slot a cycle
// tick: expiry check, batch fill by fifo pops or table pops, then the dispatch beats
// one item at a time; ready returns once the last result beat is taken, or after a tick that emits none
// reset: all control state cleared, no clearing pass; depends on dios_pkg, dios_fifo,
// dios_sort_table
module deadline_io_scheduler
    import dios_pkg::*;
#(
    parameter int MAX_REQUESTS = MAX_REQUESTS_DEF,
    parameter int MAX_BATCH    = MAX_BATCH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [15:0] sector,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [15:0] request_id,
    output logic [15:0] req_sector,
    output logic        is_write,
    output logic [31:0] finish_time,
    output logic        last,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    localparam int SLOT_W = $clog2(MAX_REQUESTS);
    localparam int BC_W   = $clog2(MAX_BATCH + 1);
    localparam int BIDX_W = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;

    typedef enum logic [11:0] {
        S_IDLE      = 12'b000000000001,
        S_SCAN      = 12'b000000000010,
        S_TCHK      = 12'b000000000100,
        S_EXPW      = 12'b000000001000,
        S_EXPR      = 12'b000000010000,
        S_FF        = 12'b000000100000,
        S_FF_WAIT   = 12'b000001000000,
        S_TF        = 12'b000010000000,
        S_FILL_DONE = 12'b000100000000,
        S_EMIT      = 12'b001000000000,
        S_EMIT_RD   = 12'b010000000000,
        S_WAIT_OUT  = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] read_dl_reg, write_dl_reg;
    logic [7:0]  starved_reg;
    logic [3:0]  batch_size_reg;

    logic [TIME_W-1:0]   time_reg;
    logic [SECTOR_W-1:0] head_pos_reg;
    logic [7:0]          rir_reg;
    logic [ID_W-1:0]     id_reg;

    logic [SECTOR_W-1:0] sec_reg;
    logic                w_reg;
    logic [SLOT_W-1:0]   scan_reg;
    logic                wexp_reg;
    logic                emit_reg;
    logic [BC_W-1:0]     bc_reg;
    logic [BIDX_W-1:0]   ei_reg;
    logic [SLOT_W-1:0]   batch_reg [MAX_BATCH];

    logic [MAX_REQUESTS-1:0] pending_reg, fifo_ref_reg, table_ref_reg, batch_ref_reg;

    store_t            store_mem [MAX_REQUESTS];
    store_t            st_rd_reg;
    logic [SLOT_W-1:0] st_raddr;
    logic              st_we;

    logic              out_valid_reg, last_reg, w_out_reg;
    logic [1:0]        kind_reg;
    logic [ID_W-1:0]   id_out_reg;
    logic [15:0]       sec_out_reg;
    logic [31:0]       time_out_reg;

    logic              rf_push, wf_push, rf_pop, wf_pop, rf_empty, wf_empty;
    logic [SLOT_W-1:0] rf_head, wf_head;
    tbl_ctrl_t         tctrl;
    logic              tbl_valid;
    logic [SLOT_W-1:0] tbl_slot;

    logic [BC_W-1:0]   lvl;
    logic              slot_free, fill_more, sel_w, ff_go, tf_go;
    logic [SLOT_W-1:0] ff_slot, emit_slot;
    logic [15:0]       seek;
    logic [TIME_W-1:0] emit_time;

    always_comb
    begin
        if (batch_size_reg == '0)
            lvl = BC_W'(1);
        else if (32'(batch_size_reg) > MAX_BATCH)
            lvl = BC_W'(MAX_BATCH);
        else
            lvl = BC_W'(batch_size_reg);
    end

    assign slot_free = !(fifo_ref_reg[scan_reg] | table_ref_reg[scan_reg]
                         | batch_ref_reg[scan_reg]);
    assign fill_more = (bc_reg < lvl);
    assign sel_w     = rf_empty ? 1'b1 : (wf_empty ? 1'b0 : (rir_reg >= starved_reg));
    assign ff_go     = fill_more && (!rf_empty || !wf_empty);
    assign tf_go     = fill_more && tbl_valid;
    assign ff_slot   = sel_w ? wf_head : rf_head;
    assign emit_slot = batch_reg[ei_reg];
    assign seek      = (st_rd_reg.sector >= head_pos_reg) ? (st_rd_reg.sector - head_pos_reg)
                                                          : (head_pos_reg - st_rd_reg.sector);
    assign emit_time = time_reg + TIME_W'(seek);

    assign st_we   = (state_reg == S_SCAN) && slot_free;
    assign rf_push = st_we && !w_reg;
    assign wf_push = st_we && w_reg;
    assign rf_pop  = (state_reg == S_FF) && ff_go && !sel_w;
    assign wf_pop  = (state_reg == S_FF) && ff_go && sel_w;

    assign tctrl.ins    = st_we;
    assign tctrl.pop    = (state_reg == S_TF) && tf_go;
    assign tctrl.sector = sec_reg;

    always_comb
    begin
        unique case (state_reg)
            S_TCHK:  st_raddr = wf_head;
            S_EXPW:  st_raddr = rf_head;
            S_EMIT:  st_raddr = emit_slot;
            default: st_raddr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[scan_reg] <= '{sector: sec_reg,
                                     expiry: time_reg + TIME_W'(w_reg ? write_dl_reg
                                                                      : read_dl_reg),
                                     id: id_reg + ID_W'(1),
                                     is_write: w_reg};
        end
        st_rd_reg <= store_mem[st_raddr];
    end

    dios_fifo #(.DEPTH(MAX_REQUESTS), .WIDTH(SLOT_W)) u_rfifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rf_push),
        .push_data (scan_reg),
        .pop       (rf_pop),
        .head_data (rf_head),
        .empty     (rf_empty)
    );

    dios_fifo #(.DEPTH(MAX_REQUESTS), .WIDTH(SLOT_W)) u_wfifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (wf_push),
        .push_data (scan_reg),
        .pop       (wf_pop),
        .head_data (wf_head),
        .empty     (wf_empty)
    );

    dios_sort_table #(.DEPTH(MAX_REQUESTS), .SLOT_W(SLOT_W)) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (tctrl),
        .new_slot   (scan_reg),
        .head_valid (tbl_valid),
        .head_slot  (tbl_slot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    if (action == ACT_READ || action == ACT_WRITE)
                        state_next = S_SCAN;
                    else if (action == ACT_TICK)
                        state_next = S_TCHK;
                end
            S_SCAN:
                if (slot_free || scan_reg == SLOT_W'(MAX_REQUESTS - 1))
                    state_next = S_WAIT_OUT;
            S_TCHK:      state_next = fill_more ? S_EXPW : S_EMIT;
            S_EXPW:      state_next = S_EXPR;
            S_EXPR:
                if (wexp_reg || (!rf_empty && time_reg > st_rd_reg.expiry))
                    state_next = S_FF;
                else if (tbl_valid)
                    state_next = S_TF;
                else
                    state_next = S_IDLE;
            S_FF:        state_next = ff_go ? S_FF_WAIT : S_FILL_DONE;
            S_FF_WAIT:   state_next = S_FF;
            S_TF:        state_next = tf_go ? S_TF : S_FILL_DONE;
            S_FILL_DONE: state_next = fill_more ? S_IDLE : S_EMIT;
            S_EMIT:      state_next = S_EMIT_RD;
            S_EMIT_RD:   state_next = S_WAIT_OUT;
            S_WAIT_OUT:
                if (out_ready)
                    state_next = last_reg ? S_IDLE : S_EMIT;
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            sec_reg <= sector;
            w_reg   <= (action == ACT_WRITE);
        end
        if (state_reg == S_EXPW)
        begin
            wexp_reg <= !wf_empty && (time_reg > st_rd_reg.expiry);
        end
        if ((state_reg == S_FF && ff_go && pending_reg[ff_slot])
            || (state_reg == S_TF && tf_go && pending_reg[tbl_slot]))
        begin
            batch_reg[bc_reg[BIDX_W-1:0]] <= (state_reg == S_FF) ? ff_slot : tbl_slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            read_dl_reg    <= READ_DL_RST;
            write_dl_reg   <= WRITE_DL_RST;
            starved_reg    <= STARVED_RST;
            batch_size_reg <= BATCH_RST;
            time_reg       <= '0;
            head_pos_reg   <= '0;
            rir_reg        <= '0;
            id_reg         <= '0;
            scan_reg       <= '0;
            emit_reg       <= 1'b0;
            bc_reg         <= '0;
            ei_reg         <= '0;
            pending_reg    <= '0;
            fifo_ref_reg   <= '0;
            table_ref_reg  <= '0;
            batch_ref_reg  <= '0;
            out_valid_reg  <= 1'b0;
            last_reg       <= 1'b0;
            kind_reg       <= KIND_ACCEPT;
            id_out_reg     <= '0;
            sec_out_reg    <= '0;
            w_out_reg      <= 1'b0;
            time_out_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_READ_DL:  read_dl_reg    <= cfg_wdata;
                    REG_WRITE_DL: write_dl_reg   <= cfg_wdata;
                    REG_STARVED:  starved_reg    <= cfg_wdata[7:0];
                    REG_BATCH:    batch_size_reg <= cfg_wdata[3:0];
                    default:      ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                    scan_reg <= '0;
                S_SCAN:
                    if (slot_free)
                    begin
                        id_reg                  <= id_reg + ID_W'(1);
                        pending_reg[scan_reg]   <= 1'b1;
                        fifo_ref_reg[scan_reg]  <= 1'b1;
                        table_ref_reg[scan_reg] <= 1'b1;
                        out_valid_reg           <= 1'b1;
                        kind_reg                <= KIND_ACCEPT;
                        id_out_reg              <= id_reg + ID_W'(1);
                        sec_out_reg             <= sec_reg;
                        w_out_reg               <= w_reg;
                        time_out_reg            <= time_reg;
                        last_reg                <= 1'b1;
                        emit_reg                <= 1'b0;
                    end
                    else if (scan_reg == SLOT_W'(MAX_REQUESTS - 1))
                    begin
                        out_valid_reg <= 1'b1;
                        kind_reg      <= KIND_DROP;
                        id_out_reg    <= '0;
                        sec_out_reg   <= sec_reg;
                        w_out_reg     <= w_reg;
                        time_out_reg  <= time_reg;
                        last_reg      <= 1'b1;
                        emit_reg      <= 1'b0;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + SLOT_W'(1);
                    end
                S_EXPR:
                    if (!(wexp_reg || (!rf_empty && time_reg > st_rd_reg.expiry)) && !tbl_valid)
                        time_reg <= time_reg + TIME_W'(1);
                S_FF:
                    if (ff_go)
                    begin
                        fifo_ref_reg[ff_slot] <= 1'b0;
                        if (pending_reg[ff_slot])
                        begin
                            pending_reg[ff_slot]   <= 1'b0;
                            batch_ref_reg[ff_slot] <= 1'b1;
                            bc_reg                 <= bc_reg + BC_W'(1);
                            if (sel_w)
                                rir_reg <= '0;
                            else if (rir_reg != 8'hFF)
                                rir_reg <= rir_reg + 8'd1;
                        end
                    end
                S_TF:
                    if (tf_go)
                    begin
                        table_ref_reg[tbl_slot] <= 1'b0;
                        if (pending_reg[tbl_slot])
                        begin
                            pending_reg[tbl_slot]   <= 1'b0;
                            batch_ref_reg[tbl_slot] <= 1'b1;
                            bc_reg                  <= bc_reg + BC_W'(1);
                        end
                    end
                S_FILL_DONE:
                    if (fill_more)
                        time_reg <= time_reg + TIME_W'(1);
                    else
                        ei_reg <= '0;
                S_TCHK:
                    ei_reg <= '0;
                S_EMIT_RD:
                begin
                    head_pos_reg             <= st_rd_reg.sector;
                    time_reg                 <= emit_time;
                    batch_ref_reg[emit_slot] <= 1'b0;
                    out_valid_reg            <= 1'b1;
                    kind_reg                 <= KIND_DISPATCH;
                    id_out_reg               <= st_rd_reg.id;
                    sec_out_reg              <= st_rd_reg.sector;
                    w_out_reg                <= st_rd_reg.is_write;
                    time_out_reg             <= emit_time;
                    last_reg                 <= (BC_W'(ei_reg) + BC_W'(1) == bc_reg);
                    emit_reg                 <= 1'b1;
                end
                S_WAIT_OUT:
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (last_reg)
                        begin
                            if (emit_reg)
                                bc_reg <= '0;
                        end
                        else
                        begin
                            ei_reg <= ei_reg + BIDX_W'(1);
                        end
                    end
                default: ;
            endcase
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign request_id  = id_out_reg;
    assign req_sector  = sec_out_reg;
    assign is_write    = w_out_reg;
    assign finish_time = time_out_reg;
    assign last        = last_reg;

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result beat waits");
    a_batch_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(bc_reg) <= MAX_BATCH)
        else $error("dispatch batch overfilled");
    a_drop_id: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_DROP) |-> (request_id == '0 && last))
        else $error("dropped arrival carries an id");
`endif
endmodule
